[rtl/ptab_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// process table engine. No dependencies.
package ptab_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int ID_W        = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int SLOT_W      = 5;
    localparam int ENTRY_W     = 2 * ID_W;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] idx;
        logic             rd_en;
        logic [IDX_W-1:0] cmp_idx;
        logic             add_wr;
        logic             set_full;
        logic             find_cap;
        logic             set_nf;
        logic             rem_mark;
        logic             rem_free;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic slot_free;
        logic hit;
    } t_sts;

endpackage

[rtl/process_table_engine_core.sv]
// Top level of the process table engine: joins the controller and the
// datapath. Depends on ptab_pkg, ptab_ctrl, ptab_dp (and ptab_ram below it).
//
// A command is taken at a rising edge where start is high and busy is low;
// busy then stays high until the result has been shown. The result appears
// on the o_ ports for exactly one cycle, marked by o_valid, and the receiver
// must take that transfer in that cycle because there is no way to stall it.
// Work is set by a scan of the table one slot per clock cycle, limited by
// the single read port of the entry RAM. An add takes the first free slot
// from slot 0 upward, or reports a full table after the last slot. A find
// compares the registered read data of each slot in turn and stops at the
// first match, or reports not found after the last slot. A remove reads
// every slot once to clear flags and then frees dead entries in the S_FREE
// state. An unknown operation code goes straight to the result and leaves
// the table unchanged. busy drops in the cycle after the result strobe,
// when the next command can be taken. The valid bits clear during reset, so
// the table is empty and ready as soon as reset is released.
module process_table_engine_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ptab_pkg::OP_W-1:0]         i_op,
    input  logic signed [ptab_pkg::ID_W-1:0]  i_proc_id,
    input  logic signed [ptab_pkg::ID_W-1:0]  i_parent_id,
    output logic                              o_valid,
    output logic [ptab_pkg::ST_W-1:0]         o_status,
    output logic [ptab_pkg::SLOT_W-1:0]       o_slot,
    output logic signed [ptab_pkg::ID_W-1:0]  o_entry_parent_id,
    output logic                              o_entry_alive,
    output logic                              o_entry_parent_alive
);

    ptab_pkg::t_cmd cmd;
    ptab_pkg::t_sts sts;

    // The controller sequences each operation and owns the scan counter.
    ptab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // The datapath holds the table and builds the result registers.
    ptab_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_proc_id            (i_proc_id),
        .i_parent_id          (i_parent_id),
        .o_sts                (sts),
        .o_status             (o_status),
        .o_slot               (o_slot),
        .o_entry_parent_id    (o_entry_parent_id),
        .o_entry_alive        (o_entry_alive),
        .o_entry_parent_alive (o_entry_parent_alive)
    );

endmodule

[rtl/ptab_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ptab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ptab_dp.sv]
// Datapath of the process table engine: entry RAM, valid and flag vectors,
// id compare and result registers. Depends on ptab_pkg and ptab_ram.
module ptab_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptab_pkg::t_cmd                    i_cmd,
    input  logic signed [ptab_pkg::ID_W-1:0]  i_proc_id,
    input  logic signed [ptab_pkg::ID_W-1:0]  i_parent_id,
    output ptab_pkg::t_sts                    o_sts,
    output logic [ptab_pkg::ST_W-1:0]         o_status,
    output logic [ptab_pkg::SLOT_W-1:0]       o_slot,
    output logic signed [ptab_pkg::ID_W-1:0]  o_entry_parent_id,
    output logic                              o_entry_alive,
    output logic                              o_entry_parent_alive
);

    logic [ptab_pkg::TABLE_SLOTS-1:0] r_valid;
    logic [ptab_pkg::TABLE_SLOTS-1:0] r_alive;
    logic [ptab_pkg::TABLE_SLOTS-1:0] r_palive;
    logic [ptab_pkg::ID_W-1:0]        r_id;
    logic [ptab_pkg::ID_W-1:0]        r_par;
    logic [ptab_pkg::ENTRY_W-1:0]     rd_data;
    logic [ptab_pkg::ID_W-1:0]        rd_pid;
    logic [ptab_pkg::ID_W-1:0]        rd_par;

    logic [ptab_pkg::ST_W-1:0]        r_status;
    logic [ptab_pkg::SLOT_W-1:0]      r_slot;
    logic [ptab_pkg::ID_W-1:0]        r_epar;
    logic                             r_ealive;
    logic                             r_epalive;

    logic [ptab_pkg::IDX_W+ptab_pkg::SLOT_W-1:0] idx_ext;
    logic [ptab_pkg::IDX_W+ptab_pkg::SLOT_W-1:0] cmp_ext;

    ptab_ram #(
        .WIDTH (ptab_pkg::ENTRY_W),
        .DEPTH (ptab_pkg::TABLE_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_wr),
        .i_waddr (i_cmd.idx),
        .i_wdata ({r_id, r_par}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.idx),
        .o_rdata (rd_data)
    );

    assign rd_pid  = rd_data[ptab_pkg::ENTRY_W-1:ptab_pkg::ID_W];
    assign rd_par  = rd_data[ptab_pkg::ID_W-1:0];
    assign idx_ext = {{ptab_pkg::SLOT_W{1'b0}}, i_cmd.idx};
    assign cmp_ext = {{ptab_pkg::SLOT_W{1'b0}}, i_cmd.cmp_idx};

    assign o_sts.slot_free = ~r_valid[i_cmd.idx];
    assign o_sts.hit       = r_valid[i_cmd.cmp_idx] && (rd_pid == r_id);

    // Valid bits are control state and clear at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.add_wr) begin
            r_valid[i_cmd.idx] <= 1'b1;
        end else if (i_cmd.rem_free) begin
            r_valid <= r_valid & (r_alive | r_palive);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id <= i_proc_id;
            r_par <= i_parent_id;
        end
        if (i_cmd.add_wr) begin
            r_alive[i_cmd.idx] <= 1'b1;
            r_palive[i_cmd.idx] <= 1'b1;
        end else if (i_cmd.rem_mark && r_valid[i_cmd.cmp_idx]) begin
            if (rd_par == r_id) begin
                r_palive[i_cmd.cmp_idx] <= 1'b0;
            end
            if (rd_pid == r_id) begin
                r_alive[i_cmd.cmp_idx] <= 1'b0;
            end
        end
    end

    // Result registers start each operation cleared to a plain done result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= ptab_pkg::ST_OK;
            r_slot <= '0;
            r_epar <= '0;
            r_ealive <= 1'b0;
            r_epalive <= 1'b0;
        end else if (i_cmd.add_wr) begin
            r_slot <= idx_ext[ptab_pkg::SLOT_W-1:0];
        end else if (i_cmd.set_full) begin
            r_status <= ptab_pkg::ST_FULL;
        end else if (i_cmd.find_cap) begin
            r_slot <= cmp_ext[ptab_pkg::SLOT_W-1:0];
            r_epar <= rd_par;
            r_ealive <= r_alive[i_cmd.cmp_idx];
            r_epalive <= r_palive[i_cmd.cmp_idx];
        end else if (i_cmd.set_nf) begin
            r_status <= ptab_pkg::ST_NOT_FOUND;
        end
    end

    assign o_status             = r_status;
    assign o_slot               = r_slot;
    assign o_entry_parent_id    = r_epar;
    assign o_entry_alive        = r_ealive;
    assign o_entry_parent_alive = r_epalive;

endmodule

[rtl/ptab_ctrl.sv]
// Controller of the process table engine: operation state machine and slot
// scan counter. Depends on ptab_pkg.
module ptab_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [ptab_pkg::OP_W-1:0]     i_op,
    input  ptab_pkg::t_sts                i_sts,
    output ptab_pkg::t_cmd                o_cmd,
    output logic                          busy,
    output logic                          o_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_FIND = 3'd2;
    localparam logic [2:0] S_REM  = 3'd3;
    localparam logic [2:0] S_FREE = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    localparam logic [ptab_pkg::CNT_W-1:0] CNT_LAST =
        ptab_pkg::CNT_W'(ptab_pkg::TABLE_SLOTS - 1);
    localparam logic [ptab_pkg::CNT_W-1:0] CNT_END =
        ptab_pkg::CNT_W'(ptab_pkg::TABLE_SLOTS);
    localparam logic [ptab_pkg::IDX_W-1:0] IDX_LAST =
        ptab_pkg::IDX_W'(ptab_pkg::TABLE_SLOTS - 1);

    logic [2:0]                    r_state, n_state;
    logic [ptab_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_cmp_vld, n_cmp_vld;
    logic [ptab_pkg::IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                          issue;

    assign issue = (r_cnt < CNT_END);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cnt[ptab_pkg::IDX_W-1:0];
        o_cmd          = '0;
        o_cmd.idx      = r_cnt[ptab_pkg::IDX_W-1:0];
        o_cmd.cmp_idx  = r_cmp_idx;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt = '0;
                    unique case (i_op)
                        ptab_pkg::OP_ADD:    n_state = S_ADD;
                        ptab_pkg::OP_FIND:   n_state = S_FIND;
                        ptab_pkg::OP_REMOVE: n_state = S_REM;
                        default:             n_state = S_RESP;
                    endcase
                end
            end
            S_ADD: begin
                priority if (i_sts.slot_free) begin
                    o_cmd.add_wr = 1'b1;
                    n_state = S_RESP;
                end else if (r_cnt == CNT_LAST) begin
                    o_cmd.set_full = 1'b1;
                    n_state = S_RESP;
                end else begin
                    n_cnt = r_cnt + ptab_pkg::CNT_W'(1);
                end
            end
            S_FIND: begin
                if (issue) begin
                    o_cmd.rd_en = 1'b1;
                    n_cnt = r_cnt + ptab_pkg::CNT_W'(1);
                    n_cmp_vld = 1'b1;
                end
                if (r_cmp_vld) begin
                    priority if (i_sts.hit) begin
                        o_cmd.find_cap = 1'b1;
                        n_state = S_RESP;
                    end else if (r_cmp_idx == IDX_LAST) begin
                        o_cmd.set_nf = 1'b1;
                        n_state = S_RESP;
                    end
                end
            end
            S_REM: begin
                if (issue) begin
                    o_cmd.rd_en = 1'b1;
                    n_cnt = r_cnt + ptab_pkg::CNT_W'(1);
                    n_cmp_vld = 1'b1;
                end
                if (r_cmp_vld) begin
                    o_cmd.rem_mark = 1'b1;
                    if (r_cmp_idx == IDX_LAST) begin
                        n_state = S_FREE;
                    end
                end
            end
            S_FREE: begin
                o_cmd.rem_free = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_RESP);

endmodule
